// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// shared property wrappers for the bounding box block
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, gated off while reset is low
`define AAC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, gated off while reset is low
`define AAC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/aac_pkg.sv =====
// ---------------------------------------------------------------------------
// aac_pkg
// types, widths, codes and helpers for the 3-D bounding box block
// ---------------------------------------------------------------------------
`default_nettype none

package aac_pkg;

    // coordinate format, signed fixed point
    localparam int COORD_BITS = 32;
    localparam int FRAC_BITS  = 16;
    localparam int AXES       = 3;

    // derived widths
    localparam int EDGE_BITS  = COORD_BITS + 1;
    localparam int SUM_BITS   = COORD_BITS + 2;
    localparam int PROD_BITS  = 2 * COORD_BITS + 1;
    localparam int SCLQ_BITS  = PROD_BITS - FRAC_BITS;
    localparam int SAT_BITS   = SCLQ_BITS + 1;
    localparam int LEFT_BITS  = EDGE_BITS + FRAC_BITS + 1;
    localparam int RIGHT_BITS = SUM_BITS + COORD_BITS;
    localparam int HI_BITS    = SUM_BITS - COORD_BITS;
    localparam int OP_BITS    = 3;
    localparam int REL_BITS   = 2;

    // stream payload layout
    localparam int IN_FIELD_BITS  = (2 * AXES + 1) * COORD_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int SCALAR_LSB     = 2 * AXES * COORD_BITS;
    localparam int OUT_FIELD_BITS = 2 * AXES * COORD_BITS + 1 + REL_BITS + 1 + 2 * EDGE_BITS;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_BITS   = OUT_DATA_BITS - OUT_FIELD_BITS;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [EDGE_BITS-1:0]  edge_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [SCLQ_BITS-1:0]  sclq_t;
    typedef logic signed [SAT_BITS-1:0]   satin_t;

    localparam coord_t CMAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t CMIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    // operation codes carried on the input user field
    typedef enum logic [OP_BITS-1:0] {
        OP_CLEAR  = 3'd0,
        OP_SPHERE = 3'd1,
        OP_BOX    = 3'd2,
        OP_GROW   = 3'd3,
        OP_MOVE   = 3'd4,
        OP_SCALE  = 3'd5,
        OP_CMP    = 3'd6
    } op_t;

    // compare outcome
    typedef enum logic [REL_BITS-1:0] {
        REL_OUTSIDE = 2'd0,
        REL_INSIDE  = 2'd1,
        REL_CROSS   = 2'd2
    } rel_t;

    // scale sequencer
    typedef enum logic [1:0] {
        SCL_IDLE = 2'd0,
        SCL_MUL  = 2'd1,
        SCL_SUM  = 2'd2,
        SCL_FIN  = 2'd3
    } scl_state_t;

    // control from the top level to every lane
    typedef struct packed {
        op_t  op;
        logic holds;
        logic other_ok;
        logic upd;
        logic fin;
        logic scl_start;
        logic scl_mul;
        logic scl_sum;
        logic s2_ld;
        logic s3_ld;
    } lane_ctrl_t;

    // what one lane hands the merging stage
    typedef struct packed {
        coord_t cmin;
        coord_t cmax;
        edge_t  edge_len;
        logic   apart;
        logic   enclosed;
        logic   close;
    } lane_res_t;

    // one result, packed in stream order (lowest field last)
    typedef struct packed {
        edge_t                  shortest_edge;
        edge_t                  longest_edge;
        logic                   similar;
        rel_t                   relation;
        logic                   box_valid;
        coord_t [AXES-1:0]      cmax;
        coord_t [AXES-1:0]      cmin;
    } result_t;

    // clamp a wide signed value to the coordinate range
    function automatic coord_t sat_coord(input satin_t v);
        coord_t r;
        if (!v[SAT_BITS-1] && (|v[SAT_BITS-2:COORD_BITS-1])) begin
            r = CMAX;
        end
        else if (v[SAT_BITS-1] && !(&v[SAT_BITS-2:COORD_BITS-1])) begin
            r = CMIN;
        end
        else begin
            r = v[COORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/aac_lane.sv =====
// ---------------------------------------------------------------------------
// aac_lane
// one axis: box corners, update, scale steps and compare datapath
// ---------------------------------------------------------------------------
`default_nettype none

module aac_lane (
    input  logic               clk,
    input  logic               rst_n,
    input  aac_pkg::lane_ctrl_t ctrl,
    input  aac_pkg::coord_t    a,
    input  aac_pkg::coord_t    b,
    input  aac_pkg::coord_t    s,
    input  aac_pkg::coord_t    tol,
    output logic               a_le_b,
    output aac_pkg::lane_res_t res
);
    import aac_pkg::*;

    // box corners for this axis
    coord_t cmin_reg, cmax_reg;
    coord_t cmin_next, cmax_next;

    // scale steps
    edge_t  dmin_reg, dmax_reg;
    coord_t fac_reg, org_reg;
    prod_t  pmin_reg, pmax_reg;
    prod_t  pmin_next, pmax_next;
    prod_t  corr_min, corr_max, fmin, fmax;
    sclq_t  qmin_reg, qmax_reg;
    coord_t scl_lo, scl_hi, scl_a, scl_b;

    // update operands
    coord_t rad, sph_lo, sph_hi;

    // compare stage one
    coord_t s1_min_reg, s1_max_reg, s1_a_reg, s1_b_reg;

    // compare stage two
    edge_t                   e_own, e_oth, dmn, dmx;
    sum_t                    sum_all;
    edge_t                   s2_edge_reg;
    logic [SUM_BITS-1:0]     msum_reg;
    logic [COORD_BITS-1:0]   mt_reg;
    logic                    rneg_reg, apart_reg, encl_reg;
    logic [EDGE_BITS-1:0]    lmin_reg, lmax_reg;
    coord_t                  s2_min_reg, s2_max_reg;

    // compare stage three
    logic [2*COORD_BITS-1:0]       rlo_reg;
    logic [HI_BITS+COORD_BITS-1:0] rhi_reg;
    logic [EDGE_BITS-1:0]          lmin3_reg, lmax3_reg;
    logic                          rneg3_reg, apart3_reg, encl3_reg;
    edge_t                         s3_edge_reg;
    coord_t                        s3_min_reg, s3_max_reg;
    logic [RIGHT_BITS-1:0]         right_val;
    logic [LEFT_BITS-1:0]          left_min, left_max;

    assign a_le_b = (a <= b);

    // sphere extent, negative radius taken as a point
    always_comb
    begin
        rad    = s[COORD_BITS-1] ? '0 : s;
        sph_lo = sat_coord(satin_t'(a) - satin_t'(rad));
        sph_hi = sat_coord(satin_t'(a) + satin_t'(rad));
    end

    // corner update for the non-scale operations and scale write-back
    always_comb
    begin
        cmin_next = cmin_reg;
        cmax_next = cmax_reg;
        if (ctrl.fin)
        begin
            cmin_next = scl_lo;
            cmax_next = scl_hi;
        end
        else
        begin
            case (ctrl.op)
                OP_CLEAR:
                begin
                    cmin_next = '0;
                    cmax_next = '0;
                end
                OP_SPHERE:
                begin
                    if (!ctrl.holds || sph_lo < cmin_reg)
                    begin
                        cmin_next = sph_lo;
                    end
                    if (!ctrl.holds || sph_hi > cmax_reg)
                    begin
                        cmax_next = sph_hi;
                    end
                end
                OP_BOX:
                begin
                    if (ctrl.other_ok && (!ctrl.holds || a < cmin_reg))
                    begin
                        cmin_next = a;
                    end
                    if (ctrl.other_ok && (!ctrl.holds || b > cmax_reg))
                    begin
                        cmax_next = b;
                    end
                end
                OP_GROW:
                begin
                    if (ctrl.holds)
                    begin
                        cmin_next = sat_coord(satin_t'(cmin_reg) - satin_t'(s));
                        cmax_next = sat_coord(satin_t'(cmax_reg) + satin_t'(s));
                    end
                end
                OP_MOVE:
                begin
                    if (ctrl.holds)
                    begin
                        cmin_next = sat_coord(satin_t'(cmin_reg) + satin_t'(a));
                        cmax_next = sat_coord(satin_t'(cmax_reg) + satin_t'(a));
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // box state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmin_reg <= '0;
            cmax_reg <= '0;
        end
        else if (ctrl.upd)
        begin
            cmin_reg <= cmin_next;
            cmax_reg <= cmax_next;
        end
    end

    // scale: distance from origin split as low word minus sign weight
    always_comb
    begin
        pmin_next = $signed({1'b0, dmin_reg[COORD_BITS-1:0]}) * fac_reg;
        pmax_next = $signed({1'b0, dmax_reg[COORD_BITS-1:0]}) * fac_reg;
        corr_min  = dmin_reg[COORD_BITS] ? (prod_t'(fac_reg) <<< COORD_BITS) : '0;
        corr_max  = dmax_reg[COORD_BITS] ? (prod_t'(fac_reg) <<< COORD_BITS) : '0;
        fmin      = pmin_reg - corr_min;
        fmax      = pmax_reg - corr_max;
    end

    // scale: origin added back, saturated, corners put in order
    always_comb
    begin
        scl_a = sat_coord(satin_t'(org_reg) + satin_t'(qmin_reg));
        scl_b = sat_coord(satin_t'(org_reg) + satin_t'(qmax_reg));
        if (scl_a > scl_b)
        begin
            scl_lo = scl_b;
            scl_hi = scl_a;
        end
        else
        begin
            scl_lo = scl_a;
            scl_hi = scl_b;
        end
    end

    // scale pipeline registers, floor shift taken as the upper bits
    always_ff @(posedge clk)
    begin
        if (ctrl.scl_start)
        begin
            dmin_reg <= edge_t'(cmin_reg) - edge_t'(b);
            dmax_reg <= edge_t'(cmax_reg) - edge_t'(b);
            fac_reg  <= a;
            org_reg  <= b;
        end
        if (ctrl.scl_mul)
        begin
            pmin_reg <= pmin_next;
            pmax_reg <= pmax_next;
        end
        if (ctrl.scl_sum)
        begin
            qmin_reg <= fmin[PROD_BITS-1:FRAC_BITS];
            qmax_reg <= fmax[PROD_BITS-1:FRAC_BITS];
        end
    end

    // compare stage one: box after the request and the other box
    always_ff @(posedge clk)
    begin
        if (ctrl.upd)
        begin
            s1_min_reg <= cmin_next;
            s1_max_reg <= cmax_next;
            s1_a_reg   <= a;
            s1_b_reg   <= b;
        end
    end

    // edge lengths, corner differences and their sum
    always_comb
    begin
        e_own   = edge_t'(s1_max_reg) - edge_t'(s1_min_reg);
        e_oth   = edge_t'(s1_b_reg) - edge_t'(s1_a_reg);
        sum_all = sum_t'(e_own) + sum_t'(e_oth);
        dmn     = edge_t'(s1_min_reg) - edge_t'(s1_a_reg);
        dmx     = edge_t'(s1_max_reg) - edge_t'(s1_b_reg);
    end

    // compare stage two
    always_ff @(posedge clk)
    begin
        if (ctrl.s2_ld)
        begin
            s2_edge_reg <= e_own;
            msum_reg    <= sum_all[SUM_BITS-1] ? SUM_BITS'(-sum_all) : SUM_BITS'(sum_all);
            mt_reg      <= tol[COORD_BITS-1] ? COORD_BITS'(-tol) : COORD_BITS'(tol);
            rneg_reg    <= (sum_all != '0) && (tol != '0) &&
                           (sum_all[SUM_BITS-1] != tol[COORD_BITS-1]);
            lmin_reg    <= dmn[EDGE_BITS-1] ? EDGE_BITS'(-dmn) : EDGE_BITS'(dmn);
            lmax_reg    <= dmx[EDGE_BITS-1] ? EDGE_BITS'(-dmx) : EDGE_BITS'(dmx);
            apart_reg   <= (s1_max_reg < s1_a_reg) || (s1_min_reg > s1_b_reg);
            encl_reg    <= (s1_min_reg <= s1_a_reg) && (s1_max_reg >= s1_b_reg);
            s2_min_reg  <= s1_min_reg;
            s2_max_reg  <= s1_max_reg;
        end
    end

    // compare stage three: tolerance product in two partial products
    always_ff @(posedge clk)
    begin
        if (ctrl.s3_ld)
        begin
            rlo_reg     <= msum_reg[COORD_BITS-1:0] * mt_reg;
            rhi_reg     <= msum_reg[SUM_BITS-1:COORD_BITS] * mt_reg;
            lmin3_reg   <= lmin_reg;
            lmax3_reg   <= lmax_reg;
            rneg3_reg   <= rneg_reg;
            apart3_reg  <= apart_reg;
            encl3_reg   <= encl_reg;
            s3_edge_reg <= s2_edge_reg;
            s3_min_reg  <= s2_min_reg;
            s3_max_reg  <= s2_max_reg;
        end
    end

    // similarity test: 2 * |d| * 2^frac against sum * tolerance
    always_comb
    begin
        right_val = RIGHT_BITS'(rlo_reg) + (RIGHT_BITS'(rhi_reg) << COORD_BITS);
        left_min  = LEFT_BITS'(lmin3_reg) << (FRAC_BITS + 1);
        left_max  = LEFT_BITS'(lmax3_reg) << (FRAC_BITS + 1);
        res.cmin     = s3_min_reg;
        res.cmax     = s3_max_reg;
        res.edge_len = s3_edge_reg;
        res.apart    = apart3_reg;
        res.enclosed = encl3_reg;
        res.close    = !rneg3_reg &&
                       (RIGHT_BITS'(left_min) <= right_val) &&
                       (RIGHT_BITS'(left_max) <= right_val);
    end

endmodule

`default_nettype wire

// ===== design/aac_merge.sv =====
// ---------------------------------------------------------------------------
// aac_merge
// combines the three lanes into one result and holds the output register
// ---------------------------------------------------------------------------
`default_nettype none

module aac_merge (
    input  logic                                  clk,
    input  logic                                  ld,
    input  logic                                  holds,
    input  logic                                  cmp,
    input  aac_pkg::lane_res_t [aac_pkg::AXES-1:0] lane_res,
    output aac_pkg::result_t                      res
);
    import aac_pkg::*;

    result_t res_reg, res_next;
    edge_t   emax, emin;
    logic    any_apart, all_encl, all_close;

    // longest and shortest edge over the axes
    always_comb
    begin
        emax = lane_res[0].edge_len;
        emin = lane_res[0].edge_len;
        for (int i = 1; i < AXES; i++)
        begin
            if (lane_res[i].edge_len > emax)
            begin
                emax = lane_res[i].edge_len;
            end
            if (lane_res[i].edge_len < emin)
            begin
                emin = lane_res[i].edge_len;
            end
        end
    end

    // relation and similarity flags
    always_comb
    begin
        any_apart = 1'b0;
        all_encl  = 1'b1;
        all_close = 1'b1;
        for (int i = 0; i < AXES; i++)
        begin
            any_apart = any_apart | lane_res[i].apart;
            all_encl  = all_encl & lane_res[i].enclosed;
            all_close = all_close & lane_res[i].close;
        end
    end

    // assemble the result
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
        begin
            res_next.cmin[i] = lane_res[i].cmin;
            res_next.cmax[i] = lane_res[i].cmax;
        end
        res_next.box_valid     = holds;
        res_next.longest_edge  = holds ? emax : '0;
        res_next.shortest_edge = holds ? emin : '0;
        res_next.similar       = cmp && all_close;
        if (!cmp || any_apart)
        begin
            res_next.relation = REL_OUTSIDE;
        end
        else if (all_encl)
        begin
            res_next.relation = REL_INSIDE;
        end
        else
        begin
            res_next.relation = REL_CROSS;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

`default_nettype wire

// ===== design/aabb_accumulate_and_classify_top.sv =====
// ---------------------------------------------------------------------------
// aabb_accumulate_and_classify_top
// 3-D bounding box accumulator and classifier, one lane per axis
// ---------------------------------------------------------------------------
//
//   channel   direction  payload                      accepted when
//   s_axis    in         tuser op, tdata vectors      tvalid & tready
//   m_axis    out        tdata box, flags, edges      tvalid & tready
//
// one request per cycle, unless the output stalls, for every operation
// except scale of a non-empty box, which closes the input while each lane
// runs subtract, 33x32 multiply and floor shift as separate register steps
// and writes its corners back. results leave through compare stages one,
// two and three and the output register. reset clears the box to zero and
// empty and drops every stage valid. a stalled output holds its result;
// the input keeps taking requests while any stage between them has room.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module aabb_accumulate_and_classify_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // vec_a_x, vec_a_y, vec_a_z, vec_b_x, vec_b_y, vec_b_z, scalar_s
    input  logic [aac_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    // op
    input  logic [aac_pkg::OP_BITS-1:0]         s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // min_x, min_y, min_z, max_x, max_y, max_z, box_valid, relation,
    // similar, longest_edge, shortest_edge, zero fill
    output logic [aac_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata
);
    import aac_pkg::*;

    op_t                 op;
    coord_t [AXES-1:0]   a_vec, b_vec;
    coord_t              scal;
    logic   [AXES-1:0]   a_le_b;
    logic                other_ok;
    logic                in_acc, scl_start, s1_load;
    logic                rdy1, rdy2, rdy3, rdy_o;
    logic                s2_load, s3_load, out_load;
    logic                scl_busy, scl_mul, scl_sum, scl_fin;

    scl_state_t          scl_state_reg, scl_state_next;
    logic                holds_box_reg, holds_box_next;
    logic                s1_vld_reg, s2_vld_reg, s3_vld_reg, out_vld_reg;
    coord_t              s1_tol_reg;
    logic                s1_holds_reg, s2_holds_reg, s3_holds_reg;
    logic                s1_cmp_reg, s2_cmp_reg, s3_cmp_reg;

    lane_ctrl_t          lane_ctrl;
    lane_res_t [AXES-1:0] lane_res;
    result_t             res;

    // unpack the request
    always_comb
    begin
        op = op_t'(s_axis_tuser);
        for (int i = 0; i < AXES; i++)
        begin
            a_vec[i] = s_axis_tdata[i*COORD_BITS +: COORD_BITS];
            b_vec[i] = s_axis_tdata[(AXES+i)*COORD_BITS +: COORD_BITS];
        end
        scal = s_axis_tdata[SCALAR_LSB +: COORD_BITS];
    end

    assign other_ok = &a_le_b;

    // stage handshake chain
    assign rdy_o    = !out_vld_reg || m_axis_tready;
    assign rdy3     = !s3_vld_reg || rdy_o;
    assign rdy2     = !s2_vld_reg || rdy3;
    assign rdy1     = !s1_vld_reg || rdy2;
    assign s2_load  = s1_vld_reg && rdy2;
    assign s3_load  = s2_vld_reg && rdy3;
    assign out_load = s3_vld_reg && rdy_o;

    assign s_axis_tready = rdy1 && !scl_busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign scl_start     = in_acc && (op == OP_SCALE) && holds_box_reg;
    assign s1_load       = (in_acc && !scl_start) || (scl_fin && rdy1);

    // scale sequencer next state
    always_comb
    begin
        scl_state_next = scl_state_reg;
        case (scl_state_reg)
            SCL_IDLE:
            begin
                if (scl_start)
                begin
                    scl_state_next = SCL_MUL;
                end
            end
            SCL_MUL:
            begin
                scl_state_next = SCL_SUM;
            end
            SCL_SUM:
            begin
                scl_state_next = SCL_FIN;
            end
            SCL_FIN:
            begin
                if (rdy1)
                begin
                    scl_state_next = SCL_IDLE;
                end
            end
            default:
            begin
                scl_state_next = SCL_IDLE;
            end
        endcase
    end

    // scale sequencer outputs
    always_comb
    begin
        scl_busy = 1'b1;
        scl_mul  = 1'b0;
        scl_sum  = 1'b0;
        scl_fin  = 1'b0;
        case (scl_state_reg)
            SCL_IDLE:
            begin
                scl_busy = 1'b0;
            end
            SCL_MUL:
            begin
                scl_mul = 1'b1;
            end
            SCL_SUM:
            begin
                scl_sum = 1'b1;
            end
            SCL_FIN:
            begin
                scl_fin = 1'b1;
            end
            default:
            begin
                scl_busy = 1'b0;
            end
        endcase
    end

    // box occupancy after the request
    always_comb
    begin
        holds_box_next = holds_box_reg;
        case (op)
            OP_CLEAR:
            begin
                holds_box_next = 1'b0;
            end
            OP_SPHERE:
            begin
                holds_box_next = 1'b1;
            end
            OP_BOX:
            begin
                if (other_ok)
                begin
                    holds_box_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scl_state_reg <= SCL_IDLE;
            holds_box_reg <= 1'b0;
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            s3_vld_reg    <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            scl_state_reg <= scl_state_next;
            if (in_acc)
            begin
                holds_box_reg <= holds_box_next;
            end
            s1_vld_reg  <= s1_load || (s1_vld_reg && !rdy2);
            s2_vld_reg  <= s2_load || (s2_vld_reg && !rdy3);
            s3_vld_reg  <= s3_load || (s3_vld_reg && !rdy_o);
            out_vld_reg <= out_load || (out_vld_reg && !m_axis_tready);
        end
    end

    // shared stage payload
    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_tol_reg   <= scal;
            s1_holds_reg <= in_acc ? holds_box_next : holds_box_reg;
            s1_cmp_reg   <= in_acc && (op == OP_CMP) && holds_box_reg && other_ok;
        end
        if (s2_load)
        begin
            s2_holds_reg <= s1_holds_reg;
            s2_cmp_reg   <= s1_cmp_reg;
        end
        if (s3_load)
        begin
            s3_holds_reg <= s2_holds_reg;
            s3_cmp_reg   <= s2_cmp_reg;
        end
    end

    // lane control
    always_comb
    begin
        lane_ctrl.op        = op;
        lane_ctrl.holds     = holds_box_reg;
        lane_ctrl.other_ok  = other_ok;
        lane_ctrl.upd       = s1_load;
        lane_ctrl.fin       = scl_fin;
        lane_ctrl.scl_start = scl_start;
        lane_ctrl.scl_mul   = scl_mul;
        lane_ctrl.scl_sum   = scl_sum;
        lane_ctrl.s2_ld     = s2_load;
        lane_ctrl.s3_ld     = s3_load;
    end

    // one lane per axis
    for (genvar g = 0; g < AXES; g++)
    begin : g_lane
        aac_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .ctrl   (lane_ctrl),
            .a      (a_vec[g]),
            .b      (b_vec[g]),
            .s      (scal),
            .tol    (s1_tol_reg),
            .a_le_b (a_le_b[g]),
            .res    (lane_res[g])
        );
    end

    // merge and output register
    aac_merge u_merge (
        .clk      (clk),
        .ld       (out_load),
        .holds    (s3_holds_reg),
        .cmp      (s3_cmp_reg),
        .lane_res (lane_res),
        .res      (res)
    );

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {{OUT_PAD_BITS{1'b0}}, res};

    // checks
    `AAC_ASSERT_IMP(a_empty_edges, clk, rst_n, m_axis_tvalid && !res.box_valid, (res.longest_edge == '0) && (res.shortest_edge == '0), "empty box with non-zero edges")
    `AAC_ASSERT_IMP(a_cmp_needs_box, clk, rst_n, m_axis_tvalid && ((res.relation != REL_OUTSIDE) || res.similar), res.box_valid, "compare flags on an empty box")
    `AAC_ASSERT_NXT(a_clear_empties, clk, rst_n, in_acc && (op == OP_CLEAR), !holds_box_reg, "clear left the box marked valid")
    `AAC_ASSERT_IMP(a_scale_on_box, clk, rst_n, scl_state_reg != SCL_IDLE, holds_box_reg && !s_axis_tready, "scale running on an empty box or with input open")

endmodule

`default_nettype wire
